FILE: rtl/slc_pkg.sv
// Shared types, constants and helpers for the set-associative LRU cache model.
// Used by every module and interface of the block; depends on nothing.
package slc_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_WIDTH   = 64;

    localparam int AGE_W       = 32;
    localparam int CNT_W       = 32;
    localparam int SHIFT_W     = 7;
    localparam int WAY_FIELD_W = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [2:0] RST_SET_BITS  = 3'd1;
    localparam logic [5:0] RST_OFFS_BITS = 6'd4;
    localparam logic [3:0] RST_WAYS      = 4'd1;

    typedef enum logic [1:0] {
        REQ_IFETCH,
        REQ_LOAD,
        REQ_STORE,
        REQ_MODIFY
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS,
        CFG_OFFS_BITS,
        CFG_WAYS_IN_USE,
        CFG_UNUSED
    } cfg_index_t;

    typedef struct packed {
        logic                   start;
        logic                   valid;
        logic [WAY_FIELD_W-1:0] way;
    } scan_ctl_t;

    typedef struct packed {
        logic                   hit;
        logic [WAY_FIELD_W-1:0] hit_way;
        logic                   empty;
        logic [WAY_FIELD_W-1:0] empty_way;
        logic [WAY_FIELD_W-1:0] min_way;
    } scan_res_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

FILE: rtl/slc_if.sv
// Channel interfaces of the cache model: request, result and configuration.
// Depends on slc_pkg for the field widths.
interface slc_req_if
    import slc_pkg::*;
#(
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [ADDR_WIDTH-1:0] addr;

    modport source (output valid, output req_type, output addr, input ready);
    modport sink   (input valid, input req_type, input addr, output ready);
endinterface

interface slc_rsp_if
    import slc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             hit;
    logic             miss;
    logic             evicted;
    logic             extra_hit;
    logic [CNT_W-1:0] hits_so_far;
    logic [CNT_W-1:0] misses_so_far;
    logic [CNT_W-1:0] evictions_so_far;
    logic             stamp_overflow;

    modport source (
        output valid, output hit, output miss, output evicted, output extra_hit,
        output hits_so_far, output misses_so_far, output evictions_so_far,
        output stamp_overflow, input ready
    );
    modport sink (
        input valid, input hit, input miss, input evicted, input extra_hit,
        input hits_so_far, input misses_so_far, input evictions_so_far,
        input stamp_overflow, output ready
    );
endinterface

interface slc_cfg_if
    import slc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/slc_store.sv
// Line store of the cache: tag and age memories, one write and one read port each.
// Depends on slc_pkg for the age width.
module slc_store
    import slc_pkg::*;
#(
    parameter int IDX_W = 9,
    parameter int TAG_W = 64
) (
    input  logic             clk,
    input  logic             we_age,
    input  logic             we_tag,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [AGE_W-1:0] wr_age,
    input  logic [TAG_W-1:0] wr_tag,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [AGE_W-1:0] rd_age,
    output logic [TAG_W-1:0] rd_tag
);

    localparam int DEPTH = 2 ** IDX_W;

    logic [AGE_W-1:0] age_mem [DEPTH];
    logic [TAG_W-1:0] tag_mem [DEPTH];
    logic [AGE_W-1:0] rd_age_reg;
    logic [TAG_W-1:0] rd_tag_reg;

    always_ff @(posedge clk)
    begin
        if (we_age)
        begin
            age_mem[wr_addr] <= wr_age;
        end
        rd_age_reg <= age_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_tag)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
        rd_tag_reg <= tag_mem[rd_addr];
    end

    assign rd_age = rd_age_reg;
    assign rd_tag = rd_tag_reg;

endmodule

FILE: rtl/slc_scan.sv
// Shared way compare unit: one tag compare and one age compare per cycle,
// accumulating hit, first empty way and oldest way over a set. Depends on slc_pkg.
module slc_scan
    import slc_pkg::*;
#(
    parameter int TAG_W = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctl_t        ctl,
    input  logic [TAG_W-1:0] tag,
    input  logic [TAG_W-1:0] rd_tag,
    input  logic [AGE_W-1:0] rd_age,
    output scan_res_t        res
);

    logic                   hit_reg, hit_next;
    logic                   empty_reg, empty_next;
    logic [WAY_FIELD_W-1:0] hit_way_reg, hit_way_next;
    logic [WAY_FIELD_W-1:0] empty_way_reg, empty_way_next;
    logic [WAY_FIELD_W-1:0] min_way_reg, min_way_next;
    logic [AGE_W-1:0]       min_age_reg, min_age_next;
    logic                   tag_eq;
    logic                   age_nz;
    logic                   age_lt;

    always_comb
    begin
        tag_eq         = (rd_tag == tag);
        age_nz         = (rd_age != '0);
        age_lt         = (rd_age < min_age_reg);
        hit_next       = hit_reg;
        hit_way_next   = hit_way_reg;
        empty_next     = empty_reg;
        empty_way_next = empty_way_reg;
        min_age_next   = min_age_reg;
        min_way_next   = min_way_reg;
        if (ctl.start)
        begin
            hit_next   = 1'b0;
            empty_next = 1'b0;
        end
        else if (ctl.valid)
        begin
            if (!hit_reg && age_nz && tag_eq)
            begin
                hit_next     = 1'b1;
                hit_way_next = ctl.way;
            end
            if (!empty_reg && !age_nz)
            begin
                empty_next     = 1'b1;
                empty_way_next = ctl.way;
            end
            if ((ctl.way == '0) || age_lt)
            begin
                min_age_next = rd_age;
                min_way_next = ctl.way;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            empty_reg     <= 1'b0;
            hit_way_reg   <= '0;
            empty_way_reg <= '0;
            min_way_reg   <= '0;
            min_age_reg   <= '0;
        end
        else
        begin
            hit_reg       <= hit_next;
            empty_reg     <= empty_next;
            hit_way_reg   <= hit_way_next;
            empty_way_reg <= empty_way_next;
            min_way_reg   <= min_way_next;
            min_age_reg   <= min_age_next;
        end
    end

    assign res = '{hit:       hit_reg,
                   hit_way:   hit_way_reg,
                   empty:     empty_reg,
                   empty_way: empty_way_reg,
                   min_way:   min_way_reg};

endmodule

FILE: rtl/set_assoc_lru_cache_sim.sv
// Top level of the set-associative LRU cache model: sequencer, counters, result register.
// Depends on slc_pkg, slc_if, slc_store and slc_scan.
//
//  Channel  Role   Word carried
//  req      sink   req_type, addr
//  rsp      source hit, miss, evicted, extra_hit, three totals, stamp_overflow
//  cfg      sink   index, data (set bits, offset bits, ways in use)
//
// A data access passes the split, scan, drain and update states from acceptance to its
// result register, and the next request is taken once the sequencer is back in idle; the
// ways of the set are read one per cycle from the single line store port.
// An instruction fetch is taken without leaving idle and gives no word.
// After reset the age memory is cleared one line per cycle, all 2**(set bits + way bits)
// lines (512 by default), with req.ready low; configuration writes are taken throughout.
// A waiting result does not block the next request; the write-back stalls until it is taken.
module set_assoc_lru_cache_sim
    import slc_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    slc_req_if.sink    req,
    slc_rsp_if.source  rsp,
    slc_cfg_if.sink    cfg
);

    localparam int SET_W  = MAX_SET_BITS;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int IDX_W  = SET_W + WAY_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [2:0]            set_bits_reg, set_bits_next;
    logic [5:0]            offs_bits_reg, offs_bits_next;
    logic [3:0]            ways_reg, ways_next;
    logic [1:0]            req_type_reg, req_type_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic [SET_W-1:0]      set_reg, set_next;
    logic [ADDR_WIDTH-1:0] tag_reg, tag_next;
    logic [WAY_W-1:0]      rd_way_reg, rd_way_next;
    logic [WAY_W-1:0]      cmp_way_reg, cmp_way_next;
    logic                  data_vld_reg, data_vld_next;
    logic [AGE_W-1:0]      stamp_reg, stamp_next;
    logic [CNT_W-1:0]      hits_reg, hits_next;
    logic [CNT_W-1:0]      misses_reg, misses_next;
    logic [CNT_W-1:0]      evicts_reg, evicts_next;
    logic                  ovf_reg, ovf_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  rsp_hit_reg, rsp_hit_next;
    logic                  rsp_evicted_reg, rsp_evicted_next;
    logic                  rsp_extra_reg, rsp_extra_next;

    logic [2:0]            sb_eff;
    logic [SET_W:0]        set_mask;
    logic [ADDR_WIDTH-1:0] addr_shifted;
    logic [SHIFT_W-1:0]    tag_shift;
    logic [4:0]            ways_wide;
    logic [WCNT_W-1:0]     ways_eff;
    logic [WAY_W-1:0]      target_way;
    logic                  advance;
    logic [CNT_W-1:0]      hits_inc;

    logic                  mem_we_age;
    logic                  mem_we_tag;
    logic [IDX_W-1:0]      mem_wr_addr;
    logic [AGE_W-1:0]      mem_wr_age;
    logic [IDX_W-1:0]      mem_rd_addr;
    logic [AGE_W-1:0]      mem_rd_age;
    logic [ADDR_WIDTH-1:0] mem_rd_tag;

    scan_ctl_t             scan_ctl;
    scan_res_t             scan_res;

    slc_store #(
        .IDX_W (IDX_W),
        .TAG_W (ADDR_WIDTH)
    ) u_store (
        .clk     (clk),
        .we_age  (mem_we_age),
        .we_tag  (mem_we_tag),
        .wr_addr (mem_wr_addr),
        .wr_age  (mem_wr_age),
        .wr_tag  (tag_reg),
        .rd_addr (mem_rd_addr),
        .rd_age  (mem_rd_age),
        .rd_tag  (mem_rd_tag)
    );

    slc_scan #(
        .TAG_W (ADDR_WIDTH)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scan_ctl),
        .tag    (tag_reg),
        .rd_tag (mem_rd_tag),
        .rd_age (mem_rd_age),
        .res    (scan_res)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.hit              = rsp_hit_reg;
    assign rsp.miss             = !rsp_hit_reg;
    assign rsp.evicted          = rsp_evicted_reg;
    assign rsp.extra_hit        = rsp_extra_reg;
    assign rsp.hits_so_far      = hits_reg;
    assign rsp.misses_so_far    = misses_reg;
    assign rsp.evictions_so_far = evicts_reg;
    assign rsp.stamp_overflow   = ovf_reg;

    assign scan_ctl = '{start: (state_reg == ST_SPLIT),
                        valid: data_vld_reg,
                        way:   WAY_FIELD_W'(cmp_way_reg)};

    always_comb
    begin
        sb_eff = ({1'b0, set_bits_reg} > 4'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_reg;
        set_mask     = ((SET_W + 1)'(1) << sb_eff) - (SET_W + 1)'(1);
        addr_shifted = addr_reg >> offs_bits_reg;
        tag_shift    = SHIFT_W'(sb_eff) + SHIFT_W'(offs_bits_reg);
        ways_wide    = {1'b0, ways_reg};
        if (ways_wide == 5'd0)
        begin
            ways_wide = 5'd1;
        end
        else if (ways_wide > 5'(MAX_WAYS))
        begin
            ways_wide = 5'(MAX_WAYS);
        end
        ways_eff = WCNT_W'(ways_wide);

        if (scan_res.hit)
        begin
            target_way = WAY_W'(scan_res.hit_way);
        end
        else if (scan_res.empty)
        begin
            target_way = WAY_W'(scan_res.empty_way);
        end
        else
        begin
            target_way = WAY_W'(scan_res.min_way);
        end

        advance = !rsp_valid_reg || rsp.ready;

        mem_we_age  = 1'b0;
        mem_we_tag  = 1'b0;
        mem_wr_addr = {set_reg, target_way};
        mem_wr_age  = stamp_reg;
        mem_rd_addr = {set_reg, rd_way_reg};
        if (state_reg == ST_CLEAR)
        begin
            mem_we_age  = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_age  = '0;
        end
        else if ((state_reg == ST_UPDATE) && advance)
        begin
            mem_we_age = 1'b1;
            mem_we_tag = !scan_res.hit;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        set_bits_next    = set_bits_reg;
        offs_bits_next   = offs_bits_reg;
        ways_next        = ways_reg;
        req_type_next    = req_type_reg;
        addr_next        = addr_reg;
        set_next         = set_reg;
        tag_next         = tag_reg;
        rd_way_next      = rd_way_reg;
        cmp_way_next     = rd_way_reg;
        data_vld_next    = (state_reg == ST_SCAN);
        stamp_next       = stamp_reg;
        hits_next        = hits_reg;
        misses_next      = misses_reg;
        evicts_next      = evicts_reg;
        ovf_next         = ovf_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_hit_next     = rsp_hit_reg;
        rsp_evicted_next = rsp_evicted_reg;
        rsp_extra_next   = rsp_extra_reg;
        hits_inc         = scan_res.hit ? sat_inc(hits_reg) : hits_reg;

        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_SET_BITS:    set_bits_next  = cfg.data[2:0];
                CFG_OFFS_BITS:   offs_bits_next = cfg.data;
                CFG_WAYS_IN_USE: ways_next      = cfg.data[3:0];
                default:         ;
            endcase
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == {IDX_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid && (req.req_type != REQ_IFETCH))
                begin
                    req_type_next = req.req_type;
                    addr_next     = req.addr;
                    state_next    = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                set_next    = SET_W'(addr_shifted) & SET_W'(set_mask);
                tag_next    = addr_reg >> tag_shift;
                rd_way_next = '0;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if ((WCNT_W'(rd_way_reg) + WCNT_W'(1)) == ways_eff)
                begin
                    rd_way_next = '0;
                    state_next  = ST_DRAIN;
                end
                else
                begin
                    rd_way_next = rd_way_reg + WAY_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (advance)
                begin
                    stamp_next = (stamp_reg != {AGE_W{1'b1}}) ? stamp_reg + AGE_W'(1)
                                                             : stamp_reg;
                    ovf_next   = ovf_reg || (stamp_next == {AGE_W{1'b1}});
                    hits_next  = (req_type_reg == REQ_MODIFY) ? sat_inc(hits_inc) : hits_inc;
                    if (!scan_res.hit)
                    begin
                        misses_next = sat_inc(misses_reg);
                        if (!scan_res.empty)
                        begin
                            evicts_next = sat_inc(evicts_reg);
                        end
                    end
                    rsp_valid_next   = 1'b1;
                    rsp_hit_next     = scan_res.hit;
                    rsp_evicted_next = !scan_res.hit && !scan_res.empty;
                    rsp_extra_next   = (req_type_reg == REQ_MODIFY);
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            set_bits_reg    <= RST_SET_BITS;
            offs_bits_reg   <= RST_OFFS_BITS;
            ways_reg        <= RST_WAYS;
            req_type_reg    <= '0;
            addr_reg        <= '0;
            set_reg         <= '0;
            tag_reg         <= '0;
            rd_way_reg      <= '0;
            cmp_way_reg     <= '0;
            data_vld_reg    <= 1'b0;
            stamp_reg       <= AGE_W'(1);
            hits_reg        <= '0;
            misses_reg      <= '0;
            evicts_reg      <= '0;
            ovf_reg         <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_hit_reg     <= 1'b0;
            rsp_evicted_reg <= 1'b0;
            rsp_extra_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            set_bits_reg    <= set_bits_next;
            offs_bits_reg   <= offs_bits_next;
            ways_reg        <= ways_next;
            req_type_reg    <= req_type_next;
            addr_reg        <= addr_next;
            set_reg         <= set_next;
            tag_reg         <= tag_next;
            rd_way_reg      <= rd_way_next;
            cmp_way_reg     <= cmp_way_next;
            data_vld_reg    <= data_vld_next;
            stamp_reg       <= stamp_next;
            hits_reg        <= hits_next;
            misses_reg      <= misses_next;
            evicts_reg      <= evicts_next;
            ovf_reg         <= ovf_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_hit_reg     <= rsp_hit_next;
            rsp_evicted_reg <= rsp_evicted_next;
            rsp_extra_reg   <= rsp_extra_next;
        end
    end

    // A stamp of zero would mark a freshly used line as empty.
    a_stamp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        stamp_reg != '0)
        else $error("access stamp reached zero");

    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.evicted |-> !rsp.hit)
        else $error("eviction reported on a hit");

    a_busy_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.req_type != REQ_IFETCH) |=> !req.ready)
        else $error("request taken while an access is in progress");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_UPDATE)
        else $error("result word raised outside the write-back step");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for set_assoc_lru_cache_sim: a directed table, then random phases of accesses.
// Each word is checked against a pinned row or the behavioural cache model kept here. Depends on slc_pkg, slc_if.
module tb_top;
    import slc_pkg::*;

    localparam int LINE_COUNT     = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 16;
    localparam int STALL_LIMIT    = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 123;
    localparam int PRESSURE_PHASE = 5;

    typedef struct packed {
        logic        hit;
        logic        miss;
        logic        evicted;
        logic        extra_hit;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
        logic        ovf;
    } outcome_t;

    typedef struct {
        bit          is_cfg;
        cfg_index_t  reg_idx;
        logic [5:0]  reg_val;
        req_type_t   kind;
        logic [63:0] addr;
        bit          pinned;
        outcome_t    want;
    } step_t;

    logic clk;
    logic rst_n;

    slc_req_if #(.ADDR_WIDTH(DEF_ADDR_WIDTH)) req ();
    slc_rsp_if rsp ();
    slc_cfg_if cfg ();

    set_assoc_lru_cache_sim i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    logic [63:0] tag_mem [LINE_COUNT];
    logic [31:0] age_mem [LINE_COUNT];
    logic [31:0] next_stamp;
    logic [31:0] hits_model;
    logic [31:0] misses_model;
    logic [31:0] evict_total;
    logic        stamp_saturated;
    logic [2:0]  geo_set_bits;
    logic [5:0]  geo_offs_bits;
    logic [3:0]  geo_ways;

    outcome_t    outcomes_due [$];
    step_t       script [$];
    bit          failed;
    bit          sender_calm;
    bit          hold_off_pending;
    logic [63:0] tag_base;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int unsigned eff_set_bits();
        return (geo_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : geo_set_bits;
    endfunction

    function automatic int unsigned eff_ways();
        if (geo_ways == 0)
            return 1;
        return (geo_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : geo_ways;
    endfunction

    function automatic void stamp_line(input int unsigned idx);
        age_mem[idx] = next_stamp;
        if (next_stamp != 32'hFFFF_FFFF)
            next_stamp = next_stamp + 32'd1;
        if (next_stamp == 32'hFFFF_FFFF)
            stamp_saturated = 1'b1;
    endfunction

    function automatic bit cache_lookup(input req_type_t kind, input logic [63:0] a,
                                        output outcome_t o);
        int unsigned sbe, nw, base, victim, idx, w;
        logic [63:0] set_no, tag;
        bit          hit, empty_found;
        o = '0;
        if (kind == REQ_IFETCH)
            return 1'b0;
        sbe = eff_set_bits();
        nw = eff_ways();
        set_no = (a >> geo_offs_bits) & ((64'd1 << sbe) - 64'd1);
        tag = a >> (sbe + geo_offs_bits);
        base = int'(set_no) * DEF_MAX_WAYS;
        hit = 1'b0;
        empty_found = 1'b0;
        for (w = 0; w < nw && !hit; w++)
        begin
            idx = base + w;
            if (age_mem[idx] != 0 && tag_mem[idx] == tag)
            begin
                stamp_line(idx);
                hits_model = bump(hits_model);
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            misses_model = bump(misses_model);
            victim = base;
            for (w = 0; w < nw && !empty_found; w++)
            begin
                idx = base + w;
                if (age_mem[idx] == 0)
                begin
                    victim = idx;
                    empty_found = 1'b1;
                end
                else if (age_mem[idx] < age_mem[victim])
                    victim = idx;
            end
            if (!empty_found)
            begin
                evict_total = bump(evict_total);
                o.evicted = 1'b1;
            end
            tag_mem[victim] = tag;
            stamp_line(victim);
        end
        if (kind == REQ_MODIFY)
            hits_model = bump(hits_model);
        o.hit = hit;
        o.miss = !hit;
        o.extra_hit = (kind == REQ_MODIFY);
        o.hits = hits_model;
        o.misses = misses_model;
        o.evictions = evict_total;
        o.ovf = stamp_saturated;
        return 1'b1;
    endfunction

    function automatic logic [63:0] pick_addr();
        int unsigned sbe, bb, r;
        logic [63:0] tag, set_no, offs;
        sbe = eff_set_bits();
        bb = geo_offs_bits;
        r = $urandom_range(0, 9);
        if (r == 0)
            return {$urandom, $urandom};
        if (r == 1)
            return $urandom_range(0, 1) ? {64{1'b1}} : 64'd0;
        tag = tag_base + 64'($urandom_range(0, 2 * eff_ways() + 1));
        set_no = 64'($urandom_range(0, (sbe > 2) ? 3 : (1 << sbe) - 1));
        offs = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
        return (tag << (sbe + bb)) | (set_no << bb) | offs;
    endfunction

    function automatic step_t row_pin(input req_type_t k, input logic [63:0] a,
                                      input bit h, input bit m, input bit e, input bit x,
                                      input int unsigned nh, input int unsigned nm,
                                      input int unsigned ne);
        step_t s;
        s.is_cfg = 1'b0;
        s.reg_idx = CFG_SET_BITS;
        s.reg_val = '0;
        s.kind = k;
        s.addr = a;
        s.pinned = 1'b1;
        s.want = '{hit: h, miss: m, evicted: e, extra_hit: x,
                   hits: nh, misses: nm, evictions: ne, ovf: 1'b0};
        return s;
    endfunction

    function automatic step_t row_acc(input req_type_t k, input logic [63:0] a);
        step_t s;
        s = row_pin(k, a, 0, 0, 0, 0, 0, 0, 0);
        s.pinned = 1'b0;
        return s;
    endfunction

    function automatic step_t row_cfg(input cfg_index_t i, input logic [5:0] v);
        step_t s;
        s = row_acc(REQ_IFETCH, '0);
        s.is_cfg = 1'b1;
        s.reg_idx = i;
        s.reg_val = v;
        return s;
    endfunction

    task automatic send_access(input req_type_t kind, input logic [63:0] a,
                               input bit pinned, input outcome_t want);
        int       gap;
        outcome_t o;
        gap = sender_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.req_type <= kind;
        req.addr     <= a;
        do @(posedge clk); while (!req.ready);
        if (cache_lookup(kind, a, o))
            outcomes_due.push_back(pinned ? want : o);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [5:0] v);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= v;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            CFG_SET_BITS:    geo_set_bits = v[2:0];
            CFG_OFFS_BITS:   geo_offs_bits = v;
            CFG_WAYS_IN_USE: geo_ways = v[3:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        req.valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    task automatic check_word(input outcome_t got);
        outcome_t want;
        if (outcomes_due.size() == 0)
        begin
            $display("%0t: word with nothing expected, got %h", $time, got);
            failed = 1'b1;
        end
        else
        begin
            want = outcomes_due.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("miss", want.miss, got.miss);
            compare_field("evicted", want.evicted, got.evicted);
            compare_field("extra_hit", want.extra_hit, got.extra_hit);
            compare_field("hits_so_far", want.hits, got.hits);
            compare_field("misses_so_far", want.misses, got.misses);
            compare_field("evictions_so_far", want.evictions, got.evictions);
            compare_field("stamp_overflow", want.ovf, got.ovf);
        end
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off on request.
    initial
    begin
        int       stall;
        int       taken;
        bit       calm;
        outcome_t got;
        taken = 0;
        calm = 1'b0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                stall = HOLD_CYCLES;
            end
            else
                stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
            taken++;
            got = '{hit: rsp.hit, miss: rsp.miss, evicted: rsp.evicted,
                    extra_hit: rsp.extra_hit, hits: rsp.hits_so_far,
                    misses: rsp.misses_so_far, evictions: rsp.evictions_so_far,
                    ovf: rsp.stamp_overflow};
            check_word(got);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        bit         last_was_write;
        int         ph;
        int         n;
        req_type_t  kind;
        logic [5:0] sb, bb, nw;
        rst_n        <= 1'b0;
        req.valid    <= 1'b0;
        req.req_type <= REQ_IFETCH;
        req.addr     <= '0;
        cfg.valid    <= 1'b0;
        cfg.index    <= CFG_SET_BITS;
        cfg.data     <= '0;
        foreach (tag_mem[i])
        begin
            tag_mem[i] = '0;
            age_mem[i] = '0;
        end
        next_stamp = 32'd1;
        hits_model = '0;
        misses_model = '0;
        evict_total = '0;
        stamp_saturated = 1'b0;
        geo_set_bits = RST_SET_BITS;
        geo_offs_bits = RST_OFFS_BITS;
        geo_ways = RST_WAYS;
        failed = 1'b0;
        sender_calm = 1'b0;
        hold_off_pending = 1'b0;
        tag_base = '0;

        // Reset geometry: two sets, sixteen-byte blocks, one way.
        script.push_back(row_pin(REQ_LOAD,   64'h0,                   0, 1, 0, 0, 0, 1, 0));
        script.push_back(row_pin(REQ_LOAD,   64'h0,                   1, 0, 0, 0, 1, 1, 0));
        script.push_back(row_acc(REQ_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF));
        script.push_back(row_pin(REQ_STORE,  64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 0, 0, 1, 2, 0));
        script.push_back(row_pin(REQ_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 1, 3, 2, 0));
        script.push_back(row_pin(REQ_LOAD,   64'h20,                  0, 1, 1, 0, 3, 3, 1));
        script.push_back(row_pin(REQ_MODIFY, 64'h0,                   0, 1, 1, 1, 4, 4, 2));
        script.push_back(row_pin(REQ_LOAD,   64'h8000_0000_0000_0000, 0, 1, 1, 0, 4, 5, 3));
        script.push_back(row_pin(REQ_STORE,  64'h10,                  0, 1, 1, 0, 4, 6, 4));
        // Out-of-range set bits and ways are clamped.
        script.push_back(row_cfg(CFG_WAYS_IN_USE, 6'd15));
        script.push_back(row_cfg(CFG_SET_BITS,    6'd7));
        script.push_back(row_cfg(CFG_OFFS_BITS,   6'd32));
        script.push_back(row_acc(REQ_LOAD,   64'h0000_0040_0000_0000));
        script.push_back(row_acc(REQ_STORE,  64'h0000_0040_0000_0000));
        script.push_back(row_acc(REQ_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF));
        script.push_back(row_acc(REQ_LOAD,   64'hFFFF_FFC0_0000_0000));
        script.push_back(row_acc(REQ_IFETCH, 64'h0));
        // A single set, ways of zero taken as one, and an ignored index.
        script.push_back(row_cfg(CFG_UNUSED,      6'h3F));
        script.push_back(row_cfg(CFG_SET_BITS,    6'd0));
        script.push_back(row_cfg(CFG_OFFS_BITS,   6'd63));
        script.push_back(row_cfg(CFG_WAYS_IN_USE, 6'd0));
        script.push_back(row_acc(REQ_LOAD,   64'h8000_0000_0000_0000));
        script.push_back(row_acc(REQ_LOAD,   64'h0));
        script.push_back(row_acc(REQ_STORE,  64'hFFFF_FFFF_FFFF_FFFF));
        // The tag shift passes the address width, so every tag is zero.
        script.push_back(row_cfg(CFG_SET_BITS,    6'd6));
        script.push_back(row_acc(REQ_LOAD,   64'hFFFF_FFFF_FFFF_FFFF));
        script.push_back(row_acc(REQ_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF));
        script.push_back(row_acc(REQ_LOAD,   64'hFFFF_FFFF_FFFF_FFFF));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        last_was_write = 1'b0;
        foreach (script[k])
        begin
            if (script[k].is_cfg)
            begin
                if (!last_was_write)
                    settle();
                write_reg(script[k].reg_idx, script[k].reg_val);
            end
            else
            begin
                if (last_was_write)
                    cfg.valid <= 1'b0;
                send_access(script[k].kind, script[k].addr, script[k].pinned, script[k].want);
            end
            last_was_write = script[k].is_cfg;
        end

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    sb = 6'd1;
                    bb = 6'd1;
                    nw = 6'd1;
                end
                1:
                begin
                    sb = 6'd6;
                    bb = 6'd32;
                    nw = 6'd8;
                end
                2:
                begin
                    sb = 6'd7;
                    bb = 6'd63;
                    nw = 6'd15;
                end
                3:
                begin
                    sb = 6'd0;
                    bb = 6'd0;
                    nw = 6'd0;
                end
                default:
                begin
                    sb = 6'($urandom_range(0, 7));
                    bb = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(1, 32));
                    nw = 6'($urandom_range(0, 15));
                end
            endcase
            write_reg(CFG_SET_BITS, sb);
            write_reg(CFG_OFFS_BITS, bb);
            write_reg(CFG_WAYS_IN_USE, nw);
            cfg.valid <= 1'b0;
            tag_base = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
            sender_calm = (ph == PRESSURE_PHASE) || ($urandom_range(0, 2) == 0);
            if (ph == PRESSURE_PHASE)
                hold_off_pending = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                kind = req_type_t'($urandom_range(0, 3));
                send_access(kind, pick_addr(), 1'b0, '0);
                n++;
            end
        end
        settle();

        if (failed)
            $display("status: fail");
        else
            $display("status: pass");
        $finish;
    end

endmodule
